[sv/mcbs_pkg.sv]
package mcbs_pkg;

  localparam int unsigned InTdataW  = 136;
  localparam int unsigned OutTdataW = 112;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [CfgIdxW-1:0] REG_OVERLAP_LIMIT = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_PENALTY_ON    = 1'd1;

  localparam logic        CMD_CLEAR    = 1'b0;
  localparam logic [15:0] PAIRS_MIN    = 16'd4;
  localparam logic signed [15:0] DETAIL_MIN = 16'sd195;
  localparam logic signed [15:0] SCALE_LO   = 16'sd234;
  // upper edge of the scale window is the low edge plus 47
  localparam logic signed [15:0] SCALE_HI   = 16'sd281;
  localparam logic [30:0] DOT_LIMIT    = 31'h147b;
  localparam logic [16:0] PENALTY_STEP = 17'd4;
  localparam logic [23:0] SUM_LOW      = 24'd6;
  localparam logic signed [16:0] BEST_LOW = 17'sd208;
  localparam logic signed [15:0] COV_LOW  = 16'sd128;
  localparam logic [23:0] SUM_MAX      = 24'hffffff;

  typedef enum logic [1:0] {
    VERDICT_CLEARED  = 2'd0,
    VERDICT_FILTERED = 2'd1,
    VERDICT_REJECTED = 2'd2,
    VERDICT_TAKEN    = 2'd3
  } verdict_t;

  typedef struct packed {
    logic               cmd;
    logic [15:0]        feature_id;
    logic [15:0]        pair_total;
    logic [7:0]         class_code;
    logic signed [15:0] overlap_value;
    logic signed [15:0] detail_raw;
    logic signed [15:0] coverage_value;
    logic signed [15:0] scale_avg;
    logic [30:0]        dot_abs;
  } item_t;

  typedef struct packed {
    logic               geo_seen;
    logic [23:0]        sum_of_pairs;
    logic signed [16:0] best_adjusted;
    logic               winner_present;
    logic signed [16:0] best_feature;
    logic signed [16:0] best_entry_detail;
    logic [15:0]        best_entry_pairs;
    logic signed [15:0] best_entry_coverage;
  } sel_state_t;

  typedef struct packed {
    logic signed [15:0] overlap_limit;
    logic               penalty_on;
  } cfg_t;

  typedef struct packed {
    verdict_t          verdict;
    logic signed [3:0] rejection_score;
  } result_t;

endpackage

[sv/match_candidate_best_selector.sv]
// path: from request accept to result valid a request passes the input reg, then the result reg
// throughput: one request per cycle unless out_tready holds the result; winner update and running sum are combinational
// a waiting result lets one more request into the input register, then in_tready drops
// reset: synchronous active-low rst_n clears both stages, the selection state
// and the registers (overlap_limit 0, penalty_on 0)
module match_candidate_best_selector (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // feature_id, pair_total, class_code, overlap_value, detail_raw,
  // coverage_value, scale_avg, dot_abs, zero fill
  input  logic [mcbs_pkg::InTdataW-1:0]     in_tdata,
  // cmd
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // has_winner, winner_id, winner_detail, winner_pairs, winner_coverage,
  // best_detail, pair_sum, rejection_score
  output logic [mcbs_pkg::OutTdataW-1:0]    out_tdata,
  // verdict
  output logic [1:0]                        out_tuser,
  input  logic                              cfg_we,
  input  logic [mcbs_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [mcbs_pkg::CfgDataW-1:0]     cfg_wdata
);
  import mcbs_pkg::*;

  logic       s1_valid_r;
  item_t      s1_item_r;
  item_t      in_item;
  cfg_t       cfg_r;
  sel_state_t state_r;
  sel_state_t state_nxt;
  result_t    res_nxt;
  logic       out_valid_r;
  verdict_t   out_verdict_r;
  logic signed [3:0] out_score_r;
  sel_state_t out_state_r;
  logic       adv;

  always_comb begin
    in_item.cmd            = in_tuser;
    in_item.feature_id     = in_tdata[15:0];
    in_item.pair_total     = in_tdata[31:16];
    in_item.class_code     = in_tdata[39:32];
    in_item.overlap_value  = signed'(in_tdata[55:40]);
    in_item.detail_raw     = signed'(in_tdata[71:56]);
    in_item.coverage_value = signed'(in_tdata[87:72]);
    in_item.scale_avg      = signed'(in_tdata[103:88]);
    in_item.dot_abs        = in_tdata[134:104];
  end

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.overlap_limit <= 16'sd0;
      cfg_r.penalty_on    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OVERLAP_LIMIT: cfg_r.overlap_limit <= signed'(cfg_wdata);
        REG_PENALTY_ON:    cfg_r.penalty_on    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r <= in_item;
    end
  end

  mcbs_eval u_eval (
    .item (s1_item_r),
    .cfg  (cfg_r),
    .cur  (state_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.geo_seen            <= 1'b0;
      state_r.sum_of_pairs        <= 24'd0;
      state_r.best_adjusted       <= 17'sd0;
      state_r.winner_present      <= 1'b0;
      state_r.best_feature        <= -17'sd1;
      state_r.best_entry_detail   <= 17'sd0;
      state_r.best_entry_pairs    <= 16'd0;
      state_r.best_entry_coverage <= 16'sd0;
    end else if (adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_verdict_r <= res_nxt.verdict;
      out_score_r   <= res_nxt.rejection_score;
      out_state_r   <= state_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_verdict_r;
  assign out_tdata  = {out_score_r,
                       out_state_r.sum_of_pairs,
                       out_state_r.best_adjusted,
                       out_state_r.best_entry_coverage,
                       out_state_r.best_entry_pairs,
                       out_state_r.best_entry_detail,
                       out_state_r.best_feature,
                       out_state_r.winner_present};

`ifndef SYNTHESIS
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!adv && rst_n) |=> $stable(state_r))
    else $error("selection state changed without a request");

  a_winner_id: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.winner_present == !state_r.best_feature[16])
    else $error("winner flag and winner id disagree");

  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_verdict_r == VERDICT_CLEARED) |->
      (out_state_r.sum_of_pairs == 24'd0 && !out_state_r.winner_present))
    else $error("clear result reports leftover state");

  a_taken_winner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_verdict_r == VERDICT_TAKEN) |->
      (out_state_r.winner_present &&
       out_state_r.best_adjusted >= out_state_r.best_entry_detail))
    else $error("taken candidate left no consistent winner");
`endif

endmodule

[sv/mcbs_eval.sv]
module mcbs_eval (
  input  mcbs_pkg::item_t    item,
  input  mcbs_pkg::cfg_t     cfg,
  input  mcbs_pkg::sel_state_t cur,
  output mcbs_pkg::sel_state_t nxt,
  output mcbs_pkg::result_t  res
);
  import mcbs_pkg::*;

  logic               early_drop;
  logic               geo_drop;
  logic               better;
  logic signed [16:0] det_ext;
  logic signed [16:0] adj;
  logic [16:0]        pen_scale;
  logic [16:0]        pen_dot;
  logic [24:0]        sum_wide;
  logic [2:0]         reason;

  always_comb begin
    early_drop = (item.pair_total <= PAIRS_MIN) || (item.class_code != 8'd0);
    geo_drop   = (item.overlap_value <= cfg.overlap_limit) ||
                 (item.detail_raw <= DETAIL_MIN);
    det_ext    = 17'(item.detail_raw);
    pen_scale  = (cfg.penalty_on &&
                  ((item.scale_avg < SCALE_LO) || (item.scale_avg > SCALE_HI)))
                 ? PENALTY_STEP : 17'd0;
    pen_dot    = (cfg.penalty_on && (item.dot_abs >= DOT_LIMIT)) ? PENALTY_STEP : 17'd0;
    adj        = det_ext - signed'(pen_scale) - signed'(pen_dot);
    sum_wide   = {1'b0, cur.sum_of_pairs} + {9'd0, item.pair_total};
    better     = !cur.winner_present || (adj > cur.best_entry_detail) ||
                 ((adj == cur.best_entry_detail) &&
                  (item.pair_total > cur.best_entry_pairs)) ||
                 ((adj == cur.best_entry_detail) &&
                  (item.pair_total == cur.best_entry_pairs) &&
                  (item.coverage_value > cur.best_entry_coverage));

    nxt = cur;
    priority if (item.cmd == CMD_CLEAR) begin
      nxt.geo_seen            = 1'b0;
      nxt.sum_of_pairs        = 24'd0;
      nxt.best_adjusted       = 17'sd0;
      nxt.winner_present      = 1'b0;
      nxt.best_feature        = -17'sd1;
      nxt.best_entry_detail   = 17'sd0;
      nxt.best_entry_pairs    = 16'd0;
      nxt.best_entry_coverage = 16'sd0;
      res.verdict = VERDICT_CLEARED;
    end else if (early_drop) begin
      res.verdict = VERDICT_FILTERED;
    end else if (geo_drop) begin
      nxt.geo_seen = 1'b1;
      res.verdict = VERDICT_REJECTED;
    end else begin
      nxt.geo_seen      = 1'b1;
      nxt.sum_of_pairs  = sum_wide[24] ? SUM_MAX : sum_wide[23:0];
      if (adj > cur.best_adjusted) begin
        nxt.best_adjusted = adj;
      end
      if (better) begin
        nxt.winner_present      = 1'b1;
        nxt.best_feature        = signed'({1'b0, item.feature_id});
        nxt.best_entry_detail   = adj;
        nxt.best_entry_pairs    = item.pair_total;
        nxt.best_entry_coverage = item.coverage_value;
      end
      res.verdict = VERDICT_TAKEN;
    end

    // score is taken from the state after this request
    reason[2] = nxt.sum_of_pairs < SUM_LOW;
    reason[1] = nxt.geo_seen && (nxt.best_adjusted < BEST_LOW);
    reason[0] = nxt.geo_seen && (nxt.best_entry_coverage < COV_LOW);
    res.rejection_score = signed'(4'd0 - {1'b0, reason});
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import mcbs_pkg::*;

  localparam logic CMD_CONSIDER = ~CMD_CLEAR;

  typedef enum logic {ROW_REQUEST, ROW_CONFIG} row_kind_t;

  typedef struct packed {
    verdict_t           verdict;
    logic               has_winner;
    logic signed [16:0] winner_id;
    logic signed [16:0] winner_detail;
    logic [15:0]        winner_pairs;
    logic signed [15:0] winner_coverage;
    logic signed [16:0] best_detail;
    logic [23:0]        pair_sum;
    logic signed [3:0]  rejection_score;
  } sel_report_t;

  typedef struct packed {
    row_kind_t            kind;
    item_t                req;
    logic                 pinned;
    sel_report_t          want;
    logic [CfgIdxW-1:0]   reg_index;
    logic [CfgDataW-1:0]  reg_value;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [InTdataW-1:0]  in_tdata = '0;
  logic                 in_tuser = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OutTdataW-1:0] out_tdata;
  logic [1:0]           out_tuser;
  logic                 cfg_we = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_wdata = '0;

  sel_state_t  sel;
  cfg_t        regs_model;
  sel_report_t pending_reports[$];
  stim_row_t   directed_rows[$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          clear_odds = 0;
  logic        hold_off = 1'b0;
  logic        start_hold = 1'b0;

  match_candidate_best_selector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver side: random stalls plus one long hold-off
  always @(negedge clk) begin
    out_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    wait (start_hold);
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
  end

  task automatic clear_selection();
    sel = '{geo_seen: 1'b0, sum_of_pairs: '0, best_adjusted: '0,
            winner_present: 1'b0, best_feature: -17'sd1, best_entry_detail: '0,
            best_entry_pairs: '0, best_entry_coverage: '0};
  endtask

  // advance the selection state by one request and report what follows
  task automatic select_candidate(input item_t rq, output sel_report_t rep);
    logic signed [16:0] adj;
    logic [24:0]        wide_sum;
    logic               better;
    logic [2:0]         why;
    verdict_t           v;
    if (rq.cmd == CMD_CLEAR) begin
      clear_selection();
      v = VERDICT_CLEARED;
    end else if (rq.pair_total <= PAIRS_MIN || rq.class_code != 8'd0) begin
      v = VERDICT_FILTERED;
    end else begin
      sel.geo_seen = 1'b1;
      if (rq.overlap_value <= regs_model.overlap_limit || rq.detail_raw <= DETAIL_MIN) begin
        v = VERDICT_REJECTED;
      end else begin
        v = VERDICT_TAKEN;
        adj = 17'(rq.detail_raw);
        if (regs_model.penalty_on) begin
          if (rq.scale_avg < SCALE_LO || rq.scale_avg > SCALE_HI) adj = adj - 17'sd4;
          if (rq.dot_abs >= DOT_LIMIT) adj = adj - 17'sd4;
        end
        wide_sum = 25'(sel.sum_of_pairs) + 25'(rq.pair_total);
        sel.sum_of_pairs = (wide_sum > 25'(SUM_MAX)) ? SUM_MAX : wide_sum[23:0];
        if (adj > sel.best_adjusted) sel.best_adjusted = adj;
        better = !sel.winner_present || adj > sel.best_entry_detail ||
                 (adj == sel.best_entry_detail && rq.pair_total > sel.best_entry_pairs) ||
                 (adj == sel.best_entry_detail && rq.pair_total == sel.best_entry_pairs &&
                  rq.coverage_value > sel.best_entry_coverage);
        if (better) begin
          sel.winner_present      = 1'b1;
          sel.best_feature        = $signed({1'b0, rq.feature_id});
          sel.best_entry_detail   = adj;
          sel.best_entry_pairs    = rq.pair_total;
          sel.best_entry_coverage = rq.coverage_value;
        end
      end
    end
    why = '0;
    if (sel.sum_of_pairs < SUM_LOW) why[2] = 1'b1;
    if (sel.geo_seen && sel.best_adjusted < BEST_LOW) why[1] = 1'b1;
    if (sel.geo_seen && sel.best_entry_coverage < COV_LOW) why[0] = 1'b1;
    rep.verdict         = v;
    rep.has_winner      = sel.winner_present;
    rep.winner_id       = sel.best_feature;
    rep.winner_detail   = sel.best_entry_detail;
    rep.winner_pairs    = sel.best_entry_pairs;
    rep.winner_coverage = sel.best_entry_coverage;
    rep.best_detail     = sel.best_adjusted;
    rep.pair_sum        = sel.sum_of_pairs;
    rep.rejection_score = -$signed({1'b0, why});
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch_results
    sel_report_t got;
    sel_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.verdict         = verdict_t'(out_tuser);
      got.has_winner      = out_tdata[0];
      got.winner_id       = out_tdata[17:1];
      got.winner_detail   = out_tdata[34:18];
      got.winner_pairs    = out_tdata[50:35];
      got.winner_coverage = out_tdata[66:51];
      got.best_detail     = out_tdata[83:67];
      got.pair_sum        = out_tdata[107:84];
      got.rejection_score = out_tdata[111:108];
      if (pending_reports.size() == 0) begin
        $display("%0t: result with no request outstanding, expected none actual %h %h",
                 $time, out_tuser, out_tdata);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        check_field("verdict", want.verdict, got.verdict);
        check_field("has_winner", want.has_winner, got.has_winner);
        check_field("winner_id", want.winner_id, got.winner_id);
        check_field("winner_detail", want.winner_detail, got.winner_detail);
        check_field("winner_pairs", want.winner_pairs, got.winner_pairs);
        check_field("winner_coverage", want.winner_coverage, got.winner_coverage);
        check_field("best_detail", want.best_detail, got.best_detail);
        check_field("pair_sum", want.pair_sum, got.pair_sum);
        check_field("rejection_score", want.rejection_score, got.rejection_score);
      end
    end
  end

  // called and returns at a falling edge
  task automatic send_request(input item_t rq, input logic pinned, input sel_report_t fixed);
    sel_report_t rep;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= rq.cmd;
    in_tdata  <= InTdataW'({rq.dot_abs, rq.scale_avg, rq.coverage_value, rq.detail_raw,
                            rq.overlap_value, rq.class_code, rq.pair_total, rq.feature_id});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    select_candidate(rq, rep);
    pending_reports.push_back(pinned ? fixed : rep);
    @(negedge clk);
  endtask

  task automatic drain_results();
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_OVERLAP_LIMIT) regs_model.overlap_limit = val;
    else regs_model.penalty_on = val[0];
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic item_t make_req(input logic cmd, input logic [15:0] id,
                                     input logic [15:0] pairs, input logic [7:0] cls,
                                     input logic [15:0] ovl, input logic [15:0] det,
                                     input logic [15:0] cov, input logic [15:0] scale,
                                     input logic [30:0] dot);
    item_t rq;
    rq.cmd = cmd;
    rq.feature_id = id;
    rq.pair_total = pairs;
    rq.class_code = cls;
    rq.overlap_value = ovl;
    rq.detail_raw = det;
    rq.coverage_value = cov;
    rq.scale_avg = scale;
    rq.dot_abs = dot;
    return rq;
  endfunction

  function automatic sel_report_t make_report(input verdict_t v, input logic hw,
                                              input int id, input int det, input int pairs,
                                              input int cov, input int best, input int sum,
                                              input int score);
    sel_report_t rep;
    rep.verdict = v;
    rep.has_winner = hw;
    rep.winner_id = 17'(id);
    rep.winner_detail = 17'(det);
    rep.winner_pairs = 16'(pairs);
    rep.winner_coverage = 16'(cov);
    rep.best_detail = 17'(best);
    rep.pair_sum = 24'(sum);
    rep.rejection_score = 4'(score);
    return rep;
  endfunction

  task automatic add_req(input item_t rq, input logic pinned, input sel_report_t want);
    stim_row_t row;
    row = '0;
    row.kind = ROW_REQUEST;
    row.req = rq;
    row.pinned = pinned;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  task automatic add_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    stim_row_t row;
    row = '0;
    row.kind = ROW_CONFIG;
    row.reg_index = idx;
    row.reg_value = val;
    directed_rows.push_back(row);
  endtask

  // mostly candidates that get through the filters, with fields bunched near thresholds
  function automatic item_t random_candidate();
    item_t rq;
    int    lim;
    int    pick;
    rq.cmd = (clear_odds != 0 && $urandom_range(clear_odds - 1) == 0) ? CMD_CLEAR : CMD_CONSIDER;
    rq.feature_id = 16'($urandom);
    rq.class_code = ($urandom_range(9) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
    pick = $urandom_range(99);
    if (pick < 8) rq.pair_total = 16'($urandom_range(0, 6));
    else if (pick < 15) rq.pair_total = 16'($urandom_range(1, 3) * 10);
    else if (pick < 25) rq.pair_total = 16'($urandom_range(7, 40));
    else rq.pair_total = 16'($urandom_range(60000, 65535));
    lim = regs_model.overlap_limit;
    if ($urandom_range(99) < 85 && lim < 32767) rq.overlap_value = 16'(lim + 1 + $urandom_range(32766 - lim));
    else rq.overlap_value = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 40) rq.detail_raw = 16'($urandom_range(190, 220));
    else if (pick < 55) rq.detail_raw = 16'($urandom);
    else if (pick < 85) rq.detail_raw = 16'($urandom_range(196, 32767));
    else rq.detail_raw = 16'($urandom_range(0, 3) * 4 + 200);
    if ($urandom_range(99) < 40) rq.coverage_value = 16'($urandom_range(120, 135));
    else rq.coverage_value = 16'($urandom);
    if ($urandom_range(1) == 0) rq.scale_avg = 16'($urandom_range(230, 285));
    else rq.scale_avg = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 40) rq.dot_abs = 31'($urandom_range(32'h1470, 32'h1480));
    else if (pick < 70) rq.dot_abs = 31'($urandom);
    else rq.dot_abs = 31'($urandom_range(0, 32'h147a));
    return rq;
  endfunction

  task automatic run_random(input int count);
    sel_report_t unused;
    unused = '0;
    repeat (count) send_request(random_candidate(), 1'b0, unused);
  endtask

  initial begin
    sel_report_t cleared;
    sel_report_t none;
    stim_row_t   row;
    none = '0;
    regs_model = '{overlap_limit: 16'sd0, penalty_on: 1'b0};
    clear_selection();
    cleared = make_report(VERDICT_CLEARED, 1'b0, -1, 0, 0, 0, 0, 0, -4);

    // reset registers: limit 0, penalties off
    add_req(make_req(CMD_CLEAR, 16'h1234, 16'h55, 8'h0, 16'h10, 16'h100, 16'h100, 16'h100, 31'h0),
            1'b1, cleared);
    add_req(make_req(CMD_CONSIDER, 16'd3, 16'd4, 8'd0, 16'd100, 16'd300, 16'd300, 16'd250, 31'd0),
            1'b1, make_report(VERDICT_FILTERED, 1'b0, -1, 0, 0, 0, 0, 0, -4));
    add_req(make_req(CMD_CONSIDER, 16'd3, 16'd5, 8'hff, 16'd100, 16'd300, 16'd300, 16'd250, 31'd0),
            1'b1, make_report(VERDICT_FILTERED, 1'b0, -1, 0, 0, 0, 0, 0, -4));
    add_req(make_req(CMD_CONSIDER, 16'd3, 16'd5, 8'd0, 16'd0, 16'd300, 16'd300, 16'd250, 31'd0),
            1'b1, make_report(VERDICT_REJECTED, 1'b0, -1, 0, 0, 0, 0, 0, -7));
    add_req(make_req(CMD_CONSIDER, 16'd3, 16'd5, 8'd0, 16'd1, 16'd195, 16'd300, 16'd250, 31'd0),
            1'b1, make_report(VERDICT_REJECTED, 1'b0, -1, 0, 0, 0, 0, 0, -7));
    add_req(make_req(CMD_CONSIDER, 16'd7, 16'd5, 8'd0, 16'd1, 16'd196, 16'd200, 16'd250, 31'd0),
            1'b1, make_report(VERDICT_TAKEN, 1'b1, 7, 196, 5, 200, 196, 5, -6));
    add_req(make_req(CMD_CONSIDER, 16'hffff, 16'hffff, 8'd0, 16'h7fff, 16'h7fff, 16'h8000,
                     16'h8000, 31'h7fffffff), 1'b0, none);
    // same detail and count: coverage breaks the tie
    add_req(make_req(CMD_CONSIDER, 16'd1, 16'hffff, 8'd0, 16'h7fff, 16'h7fff, 16'h7fff,
                     16'h7fff, 31'h0), 1'b0, none);
    add_req(make_req(CMD_CONSIDER, 16'd2, 16'hffff, 8'd0, 16'h7fff, 16'h7fff, 16'h0,
                     16'h0, 31'h0), 1'b0, none);
    add_req(make_req(CMD_CONSIDER, 16'd9, 16'h8000, 8'd0, 16'h7fff, 16'h8000, 16'h7fff,
                     16'h0, 31'h0), 1'b0, none);
    add_cfg(REG_PENALTY_ON, 16'd1);
    add_cfg(REG_OVERLAP_LIMIT, 16'h8000);
    add_req(make_req(CMD_CONSIDER, 16'd10, 16'd20, 8'd0, 16'h8000, 16'd250, 16'd130, 16'd250,
                     31'd0), 1'b0, none);
    // scale window edges and the dot threshold
    add_req(make_req(CMD_CONSIDER, 16'd11, 16'd20, 8'd0, 16'h8001, 16'd250, 16'd130, 16'd233,
                     31'h147a), 1'b0, none);
    add_req(make_req(CMD_CONSIDER, 16'd12, 16'd20, 8'd0, 16'h8001, 16'd250, 16'd130, 16'd234,
                     31'h147b), 1'b0, none);
    add_req(make_req(CMD_CONSIDER, 16'd13, 16'd20, 8'd0, 16'h8001, 16'd250, 16'd130, 16'd281,
                     31'h0), 1'b0, none);
    add_req(make_req(CMD_CONSIDER, 16'd14, 16'd20, 8'd0, 16'h8001, 16'd250, 16'd130, 16'd282,
                     31'h7fffffff), 1'b0, none);
    add_req(make_req(CMD_CONSIDER, 16'd15, 16'd20, 8'd0, 16'h8001, 16'd196, 16'd130, 16'h7fff,
                     31'h7fffffff), 1'b0, none);
    add_req(make_req(CMD_CLEAR, 16'hffff, 16'hffff, 8'hff, 16'hffff, 16'hffff, 16'hffff,
                     16'hffff, 31'h7fffffff), 1'b1, cleared);
    add_cfg(REG_OVERLAP_LIMIT, 16'h7fff);
    add_req(make_req(CMD_CONSIDER, 16'd16, 16'd10, 8'd0, 16'h7fff, 16'h7fff, 16'h7fff, 16'd250,
                     31'd0), 1'b1, make_report(VERDICT_REJECTED, 1'b0, -1, 0, 0, 0, 0, 0, -7));
    add_cfg(REG_OVERLAP_LIMIT, 16'd0);
    add_cfg(REG_PENALTY_ON, 16'd0);
    add_req(make_req(CMD_CONSIDER, 16'd17, 16'd6, 8'd0, 16'd1, 16'd208, 16'd128, 16'd250,
                     31'd0), 1'b0, none);

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CONFIG) begin
        in_tvalid <= 1'b0;
        drain_results();
        write_reg(row.reg_index, row.reg_value);
      end else begin
        send_request(row.req, row.pinned, row.want);
      end
    end

    in_tvalid <= 1'b0;
    drain_results();
    write_reg(REG_OVERLAP_LIMIT, 16'd100);
    write_reg(REG_PENALTY_ON, 16'd1);
    send_idle_pct = 7;
    recv_idle_pct = 82;
    clear_odds = 60;
    run_random(350);

    in_tvalid <= 1'b0;
    drain_results();
    write_reg(REG_OVERLAP_LIMIT, 16'($urandom_range(0, 65535)));
    write_reg(REG_PENALTY_ON, 16'd0);
    send_idle_pct = 82;
    recv_idle_pct = 7;
    clear_odds = 200;
    run_random(350);

    // no clears here so the running sum reaches its ceiling
    in_tvalid <= 1'b0;
    drain_results();
    write_reg(REG_OVERLAP_LIMIT, 16'h8000);
    write_reg(REG_PENALTY_ON, 16'd1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    clear_odds = 0;
    start_hold = 1'b1;
    run_random(580);

    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
sv/mcbs_pkg.sv
sv/mcbs_eval.sv
sv/match_candidate_best_selector.sv
sim/tb_top.sv
